### hdl/hpcv_pkg.sv
// Shared types, codes and constants for the hall phase counter velocity block.
package hpcv_pkg;

  // Item kinds on the event channel.
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    PHASE_A    = 2'd0,
    PHASE_B    = 2'd1,
    PHASE_C    = 2'd2,
    PHASE_NONE = 2'd3
  } phase_t;

  // Configuration space.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_VELOCITY_SCALE = 1'b0;
  localparam logic [31:0] VELOCITY_SCALE_RESET = 32'd65536;

  localparam int unsigned QUEUE_DEPTH = 4;

  // One sampled tick travelling from the front to the back.
  typedef struct packed {
    logic signed [31:0] total_count;
    logic signed [31:0] count_delta;
  } sample_t;

  // Forward predecessor of a phase: B before A, C before B, A before C.
  function automatic phase_t pred_of(input phase_t p);
    phase_t r;
    case (p)
      PHASE_A: r = PHASE_B;
      PHASE_B: r = PHASE_C;
      PHASE_C: r = PHASE_A;
      default: r = PHASE_NONE;
    endcase
    return r;
  endfunction

endpackage

### hdl/hpcv_ifs.sv
// Valid/ready channel interfaces for hall events and velocity results.
interface hpcv_event_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] phase;

  modport source (output valid, output kind, output phase, input ready);
  modport sink   (input valid, input kind, input phase, output ready);
endinterface

interface hpcv_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] total_count;
  logic signed [31:0] count_delta;
  logic signed [31:0] velocity_q16;

  modport source (output valid, output total_count, output count_delta,
                  output velocity_q16, input ready);
  modport sink   (input valid, input total_count, input count_delta,
                  input velocity_q16, output ready);
endinterface

### hdl/hpcv_queue.sv
// Short first-in first-out queue of sampled ticks between front and back.
module hpcv_queue #(
  parameter int unsigned DEPTH = hpcv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hpcv_pkg::sample_t push_data,
  input  logic             pop,
  output hpcv_pkg::sample_t pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hpcv_pkg::sample_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

### hdl/hpcv_front.sv
// Front end: takes hall edges and ticks, keeps the running count, queues samples.
module hpcv_front (
  input  logic               clk,
  input  logic               rst,
  hpcv_event_if.sink         events,
  input  logic               q_full,
  output logic               q_push,
  output hpcv_pkg::sample_t  q_data
);

  // Only the sum of the three phase counters is ever observed, so the
  // running total is kept directly; it wraps exactly as the sum would.
  logic [31:0]      total;
  logic [31:0]      total_next;
  logic [31:0]      prev_total;
  hpcv_pkg::phase_t prev_phase;
  hpcv_pkg::phase_t phase_in;
  logic             accept;
  logic             is_edge;
  logic             step_up;

  assign events.ready = !q_full;
  assign accept       = events.valid && events.ready;
  assign phase_in     = hpcv_pkg::phase_t'(events.phase);
  assign is_edge      = accept && (events.kind == hpcv_pkg::KIND_EDGE)
                        && (phase_in != hpcv_pkg::PHASE_NONE);
  assign step_up      = (prev_phase == hpcv_pkg::pred_of(phase_in));
  assign total_next   = step_up ? total + 32'd1 : total - 32'd1;

  assign q_push             = accept && (events.kind == hpcv_pkg::KIND_TICK);
  assign q_data.total_count = total;
  assign q_data.count_delta = total - prev_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      prev_total <= '0;
      prev_phase <= hpcv_pkg::PHASE_NONE;
    end else begin
      if (is_edge) begin
        total      <= total_next;
        prev_phase <= phase_in;
      end
      if (q_push) begin
        prev_total <= total;
      end
    end
  end

endmodule

### hdl/hpcv_back.sv
// Back end: scales the count delta to a saturated Q16.16 velocity, two stages.
module hpcv_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        velocity_scale,
  input  logic               q_empty,
  input  hpcv_pkg::sample_t  q_data,
  output logic               q_pop,
  hpcv_result_if.source      results
);

  logic              adv;
  logic              s1_valid;
  hpcv_pkg::sample_t s1_sample;
  logic              s1_neg;
  logic [63:0]       s1_prod;
  logic [31:0]       mag;
  logic [63:0]       prod_up;
  logic [47:0]       q_neg;
  logic signed [31:0] vel;

  // The whole back pipeline moves whenever the output register is free.
  assign adv   = !results.valid || results.ready;
  assign q_pop = adv && !q_empty;

  // Magnitude of the delta; the most negative delta maps to 2^31.
  assign mag = q_data.count_delta[31] ? (~q_data.count_delta + 32'd1)
                                      : q_data.count_delta;

  // Floor of a negative value: round the magnitude up before shifting.
  assign prod_up = s1_prod + 64'h0000_0000_0000_FFFF;
  assign q_neg   = prod_up[63:16];

  always_comb begin
    if (!s1_neg) begin
      vel = (|s1_prod[63:47]) ? 32'sh7FFF_FFFF : $signed(s1_prod[47:16]);
    end else begin
      vel = (|q_neg[47:31]) ? 32'sh8000_0000 : $signed(~q_neg[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample            <= q_data;
      s1_neg               <= q_data.count_delta[31];
      s1_prod              <= 64'(mag) * 64'(velocity_scale);
      results.total_count  <= s1_sample.total_count;
      results.count_delta  <= s1_sample.count_delta;
      results.velocity_q16 <= vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      results.valid <= 1'b0;
    end else if (adv) begin
      s1_valid      <= !q_empty;
      results.valid <= s1_valid;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
      (s1_valid && !adv) |=> (s1_valid && $stable(s1_prod)))
    else $error("multiplier stage lost a held sample");

endmodule

### hdl/hall_phase_counter_velocity_core.sv
// Top level of the hall phase counter velocity block.
//
// Items arrive on the events channel: an edge (kind 0) on phase A, B or C
// steps the position count up when the previous phase was the forward
// predecessor and down otherwise; phase code three is dropped. A tick
// (kind 1) samples the total count, the delta against the last sample and
// the delta scaled by velocity_scale (Q16.16, floored, saturated).
// Edges produce no beat on the results channel; each tick produces one.
// The block takes one item per cycle while the sample queue has room. A
// tick's result passes through the sample queue, the 32x32 multiplier
// stage and then the output register.
// A stalled receiver holds the output register; the four-entry sample queue
// keeps events flowing until it fills, then events.ready falls.
// Reset clears the count, the last sample and the phase history, and loads
// velocity_scale with 1.0 (65536). velocity_scale is at APB address 0.
module hall_phase_counter_velocity_core #(
  parameter int unsigned QUEUE_DEPTH = hpcv_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hpcv_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hpcv_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hpcv_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  hpcv_event_if.sink                        events,
  hpcv_result_if.source                     results
);

  logic [31:0]       velocity_scale;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  hpcv_pkg::sample_t push_data;
  hpcv_pkg::sample_t pop_data;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == hpcv_pkg::REG_VELOCITY_SCALE);
  assign prdata  = reg_hit ? velocity_scale : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_scale <= hpcv_pkg::VELOCITY_SCALE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      velocity_scale <= pwdata;
    end
  end

  hpcv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .events (events),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  hpcv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  hpcv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .velocity_scale (velocity_scale),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .results        (results)
  );

endmodule

### dv/hall_phase_counter_velocity_core_tb.sv
// Self-checking testbench for the hall phase counter velocity core.
module hall_phase_counter_velocity_core_tb;
  import hpcv_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 64;
  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;
  localparam logic [APB_ADDR_W-1:0] SCALE_ADDR = APB_ADDR_W'(4 * int'(REG_VELOCITY_SCALE));

  typedef struct packed {
    logic signed [31:0] total_count;
    logic signed [31:0] count_delta;
    logic signed [31:0] velocity_q16;
  } tick_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  hpcv_event_if ev_if ();
  hpcv_result_if res_if ();

  hall_phase_counter_velocity_core uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .events  (ev_if),
    .results (res_if)
  );

  // Copy of the block's state, advanced on every accepted beat.
  logic [31:0] pos_count [3] = '{32'd0, 32'd0, 32'd0};
  phase_t seen_phase = PHASE_NONE;
  logic [31:0] sampled_total = 32'd0;
  logic [31:0] scale_q16 = VELOCITY_SCALE_RESET;
  tick_sample_t samples_due [$];

  int mismatches = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int holds_asked = 0;
  int holds_served = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %0s: got %08h, expected %08h", what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [31:0] scaled_velocity(input logic signed [31:0] delta,
                                                         input logic [31:0] gain);
    longint prod;
    longint q;
    prod = longint'(delta) * longint'({32'd0, gain});
    q = prod >>> 16;
    if (q > VEL_MAX) return 32'sh7FFF_FFFF;
    if (q < VEL_MIN) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  // Next phase in the forward rotation, A then C then B then A.
  function automatic logic [1:0] forward_after(input phase_t q);
    case (q)
      PHASE_A: return PHASE_C;
      PHASE_B: return PHASE_A;
      PHASE_C: return PHASE_B;
      default: return PHASE_A;
    endcase
  endfunction

  function automatic logic [1:0] backward_after(input phase_t q);
    case (q)
      PHASE_A: return PHASE_B;
      PHASE_B: return PHASE_C;
      PHASE_C: return PHASE_A;
      default: return PHASE_B;
    endcase
  endfunction

  task automatic track_beat(input logic k, input logic [1:0] p);
    phase_t lead;
    tick_sample_t s;
    logic [31:0] total;
    if (k == KIND_EDGE) begin
      if (phase_t'(p) == PHASE_NONE) return;
      lead = (phase_t'(p) == PHASE_C) ? PHASE_A : phase_t'(p + 2'd1);
      if (seen_phase == lead) pos_count[p] = pos_count[p] + 32'd1;
      else pos_count[p] = pos_count[p] - 32'd1;
      seen_phase = phase_t'(p);
    end else begin
      total = pos_count[0] + pos_count[1] + pos_count[2];
      s.total_count = total;
      s.count_delta = total - sampled_total;
      s.velocity_q16 = scaled_velocity(s.count_delta, scale_q16);
      sampled_total = total;
      samples_due.push_back(s);
    end
  endtask

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input logic k, input logic [1:0] p);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
        if (gap != 0) begin
          ev_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    ev_if.valid <= 1'b1;
    ev_if.kind <= k;
    ev_if.phase <= p;
    do @(posedge clk); while (!ev_if.ready);
    track_beat(k, p);
  endtask

  task automatic quiesce();
    ev_if.valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    // Edges leave no result behind, so give any trailing one time to land.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_read(output logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= SCALE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // The read-back transfer follows the write access directly.
  task automatic set_scale(input logic [31:0] value);
    logic [APB_DATA_W-1:0] readback;
    quiesce();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SCALE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    scale_q16 = value;
    apb_read(readback);
    if (readback !== value) report_mismatch("velocity_scale readback", readback, value);
  endtask

  // Steps the count until the pending delta reaches the target, then ticks.
  task automatic drive_delta(input logic signed [31:0] target);
    logic signed [31:0] pending;
    pending = pos_count[0] + pos_count[1] + pos_count[2] - sampled_total;
    while (pending != target) begin
      if (pending < target) send_beat(KIND_EDGE, forward_after(seen_phase));
      else send_beat(KIND_EDGE, (seen_phase == PHASE_NONE) ? PHASE_A : seen_phase);
      pending = pos_count[0] + pos_count[1] + pos_count[2] - sampled_total;
    end
    send_beat(KIND_TICK, 2'($urandom_range(0, 3)));
  endtask

  task automatic run_traffic(input int n_items);
    int done;
    int run_len;
    int shape;
    logic k;
    logic [1:0] p;
    done = 0;
    while (done < n_items) begin
      shape = $urandom_range(0, 99);
      run_len = $urandom_range(2, 20);
      for (int i = 0; i < run_len; i++) begin
        k = ($urandom_range(0, 5) == 0) ? KIND_TICK : KIND_EDGE;
        if (shape < 55) p = forward_after(seen_phase);
        else if (shape < 75) p = backward_after(seen_phase);
        else if (shape < 85) p = (seen_phase == PHASE_NONE) ? PHASE_A : seen_phase;
        else begin
          k = 1'($urandom_range(0, 1));
          p = 2'($urandom_range(0, 3));
        end
        if (k == KIND_TICK) p = 2'($urandom_range(0, 3));
        send_beat(k, p);
        if (!(k == KIND_EDGE && phase_t'(p) == PHASE_NONE)) done++;
      end
    end
  endtask

  task automatic test_reset_state();
    logic [APB_DATA_W-1:0] readback;
    apb_read(readback);
    if (readback !== VELOCITY_SCALE_RESET)
      report_mismatch("velocity_scale after reset", readback, VELOCITY_SCALE_RESET);
    send_beat(KIND_TICK, PHASE_A);
  endtask

  task automatic test_edge_rules();
    send_beat(KIND_EDGE, PHASE_A);   // first edge after reset counts down
    send_beat(KIND_EDGE, PHASE_A);   // repeated phase
    send_beat(KIND_EDGE, PHASE_C);
    send_beat(KIND_EDGE, PHASE_B);
    send_beat(KIND_EDGE, PHASE_A);
    send_beat(KIND_TICK, PHASE_C);
    send_beat(KIND_EDGE, PHASE_B);   // backward steps
    send_beat(KIND_EDGE, PHASE_C);
    send_beat(KIND_TICK, PHASE_B);
    // The dropped code must not disturb the phase history.
    send_beat(KIND_EDGE, PHASE_NONE);
    send_beat(KIND_EDGE, PHASE_B);
    send_beat(KIND_TICK, PHASE_NONE);
    send_beat(KIND_TICK, PHASE_A);
  endtask

  task automatic test_velocity_rounding();
    set_scale(32'd1);
    drive_delta(-32'sd1);
    drive_delta(32'sd1);
    set_scale(32'h0000_8000);
    drive_delta(-32'sd3);
    drive_delta(32'sd3);
    set_scale(32'd0);
    drive_delta(-32'sd2);
    set_scale(32'hFFFF_FFFF);
    drive_delta(32'sd5);
    drive_delta(-32'sd5);
  endtask

  task automatic test_scale_sweep();
    logic [31:0] scales [9];
    scales = '{32'd0, 32'd1, 32'h0000_8000, 32'h0001_0000, 32'h0001_8000,
               32'h7FFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom};
    foreach (scales[i]) begin
      set_scale(scales[i]);
      run_traffic(150);
    end
  endtask

  task automatic test_random_traffic();
    set_scale(32'h0003_2000);
    run_traffic(350);
    // Let everything drain before carrying on.
    quiesce();
    run_traffic(350);
    quiesce();
  endtask

  task automatic test_backpressure();
    holds_asked <= holds_asked + 1;
    gaps_on = 1'b0;
    for (int i = 0; i < 48; i++) begin
      if (i % 3 == 2) send_beat(KIND_EDGE, forward_after(seen_phase));
      else send_beat(KIND_TICK, 2'($urandom_range(0, 3)));
    end
    gaps_on = 1'b1;
    quiesce();
  endtask

  // Receiver: random runs of differing acceptance, plus long holds on request.
  initial begin
    int run_left;
    int accept_pct;
    run_left = 0;
    accept_pct = 100;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served <= holds_served + 1;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0: accept_pct = 100;
            1: accept_pct = 75;
            2: accept_pct = 40;
            default: accept_pct = 10;
          endcase
        end
        run_left--;
        res_if.ready <= ($urandom_range(1, 100) <= accept_pct);
      end
    end
  end

  always @(posedge clk) begin
    tick_sample_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (samples_due.size() == 0) begin
        report_mismatch("unexpected result beat", res_if.total_count, 32'd0);
      end else begin
        want = samples_due.pop_front();
        if (res_if.total_count !== want.total_count)
          report_mismatch("total_count", res_if.total_count, want.total_count);
        if (res_if.count_delta !== want.count_delta)
          report_mismatch("count_delta", res_if.count_delta, want.count_delta);
        if (res_if.velocity_q16 !== want.velocity_q16)
          report_mismatch("velocity_q16", res_if.velocity_q16, want.velocity_q16);
      end
    end
  end

  initial begin
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    ev_if.valid <= 1'b0;
    ev_if.kind <= KIND_EDGE;
    ev_if.phase <= PHASE_A;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_edge_rules();
    test_velocity_rounding();
    test_scale_sweep();
    test_random_traffic();
    test_backpressure();
    quiesce();
    if (mismatches == 0) begin
      $display("hall_phase_counter_velocity_core_tb: PASS");
    end else begin
      $display("hall_phase_counter_velocity_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(2 * 4_000_000);
    $display("hall_phase_counter_velocity_core_tb: FAIL");
    $finish;
  end

endmodule

### hall_phase_counter_velocity_core.f
hdl/hpcv_pkg.sv
hdl/hpcv_ifs.sv
hdl/hpcv_queue.sv
hdl/hpcv_front.sv
hdl/hpcv_back.sv
hdl/hall_phase_counter_velocity_core.sv
dv/hall_phase_counter_velocity_core_tb.sv
